FILE: sv/time_of_day_clock_with_keypad_set_defines.svh
// assertion macros shared by the time-of-day clock modules
`ifndef TIME_OF_DAY_CLOCK_WITH_KEYPAD_SET_DEFINES_SVH
`define TIME_OF_DAY_CLOCK_WITH_KEYPAD_SET_DEFINES_SVH

// same-cycle implication, checked on every clock outside reset
`define TOD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tod same-cycle check failed");

// next-cycle implication, checked on every clock outside reset
`define TOD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tod next-cycle check failed");

`endif

FILE: sv/tod_pkg.sv
// shared types and constants for the time-of-day clock
package tod_pkg;

    // function codes of an input item
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_KEY  = 2'd1;
    localparam logic [1:0] FUNC_SCAN = 2'd2;

    // number of multiplexed display positions
    localparam int unsigned DISPLAY_DIGITS = 6;

    // active-low select with every position off
    localparam logic [5:0] SEL_NONE = 6'h3F;

    // one result of the clock
    typedef struct packed {
        logic [7:0] hours;
        logic [7:0] minutes;
        logic [7:0] seconds;
        logic [2:0] entry_step;
        logic       wrong_choice;
        logic [4:0] digit_value;
        logic [5:0] digit_select;
    } tod_result_t;

endpackage

FILE: sv/tod_digit.sv
// display scan: picks one decimal digit of the time and its select line
module tod_digit
    import tod_pkg::*;
(
    input  logic [7:0] sec_count,
    input  logic [7:0] min_count,
    input  logic [7:0] hour_count,
    input  logic [2:0] scan_position,
    output logic [4:0] digit_value,
    output logic [5:0] digit_select,
    output logic [2:0] scan_next
);

    localparam logic [2:0] LAST_POS = 3'(DISPLAY_DIGITS - 1);

    logic [2:0]  pos;
    logic [7:0]  src;
    logic        want_tens;
    logic [15:0] prod;
    logic [4:0]  quot;
    logic [7:0]  quot_x10;
    logic [7:0]  rem;

    // out-of-range position counts as the first one
    assign pos = (scan_position > LAST_POS) ? 3'd0 : scan_position;
    assign scan_next = (pos == LAST_POS) ? 3'd0 : pos + 3'd1;

    // counter and select for the position
    always_comb
    begin
        src          = sec_count;
        want_tens    = 1'b0;
        digit_select = 6'h1F;
        case (pos)
            3'd0:
            begin
                src          = sec_count;
                want_tens    = 1'b0;
                digit_select = 6'h1F;
            end
            3'd1:
            begin
                src          = sec_count;
                want_tens    = 1'b1;
                digit_select = 6'h3E;
            end
            3'd2:
            begin
                src          = min_count;
                want_tens    = 1'b0;
                digit_select = 6'h3D;
            end
            3'd3:
            begin
                src          = min_count;
                want_tens    = 1'b1;
                digit_select = 6'h3B;
            end
            3'd4:
            begin
                src          = hour_count;
                want_tens    = 1'b0;
                digit_select = 6'h37;
            end
            default:
            begin
                src          = hour_count;
                want_tens    = 1'b1;
                digit_select = 6'h2F;
            end
        endcase
    end

    // divide by ten through the reciprocal 205/2048, exact for 8-bit values
    assign prod     = {8'd0, src} * 16'd205;
    assign quot     = prod[15:11];
    assign quot_x10 = 8'({3'd0, quot} * 8'd10);
    assign rem      = src - quot_x10;

    assign digit_value = want_tens ? quot : rem[4:0];

endmodule

FILE: sv/tod_core.sv
// clock state: counters, keypad entry sequencer and scan position
`include "time_of_day_clock_with_keypad_set_defines.svh"

module tod_core
    import tod_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        proc,
    input  logic [1:0]  func,
    input  logic [7:0]  key_code,
    output tod_result_t result
);

    // entry sequencer states
    localparam logic [2:0] ENTRY_IDLE      = 3'd0;
    localparam logic [2:0] ENTRY_HOUR_TENS = 3'd1;
    localparam logic [2:0] ENTRY_HOUR_UNIT = 3'd2;
    localparam logic [2:0] ENTRY_MIN_TENS  = 3'd3;
    localparam logic [2:0] ENTRY_MIN_UNIT  = 3'd4;
    localparam logic [2:0] ENTRY_SEC_TENS  = 3'd5;
    localparam logic [2:0] ENTRY_SEC_UNIT  = 3'd6;

    localparam logic [7:0] KEY_ZERO = 8'd48;
    localparam logic [7:0] KEY_ONE  = 8'd49;

    logic [7:0] sec_reg,   sec_next;
    logic [7:0] min_reg,   min_next;
    logic [7:0] hour_reg,  hour_next;
    logic [2:0] entry_reg, entry_next;
    logic       wrong_reg, wrong_next;
    logic [2:0] scan_reg,  scan_next;

    logic [2:0] scan_adv;
    logic [4:0] scan_value;
    logic [5:0] scan_select;

    logic [7:0] key_digit;
    logic [7:0] key_tens;
    logic [7:0] sec_inc;
    logic [7:0] min_tick;
    logic [7:0] hour_tick;

    tod_digit u_digit (
        .sec_count    (sec_reg),
        .min_count    (min_reg),
        .hour_count   (hour_reg),
        .scan_position(scan_reg),
        .digit_value  (scan_value),
        .digit_select (scan_select),
        .scan_next    (scan_adv)
    );

    // key digit and its tens weight, both wrapping to 8 bits
    assign key_digit = key_code - KEY_ZERO;
    assign key_tens  = 8'(key_digit * 8'd10);

    // one-second increment with carries
    assign sec_inc   = sec_reg + 8'd1;
    assign min_tick  = (sec_inc >= 8'd60) ? min_reg + 8'd1 : min_reg;
    assign hour_tick = (min_tick >= 8'd60) ? hour_reg + 8'd1 : hour_reg;

    // next state for the item
    always_comb
    begin
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        entry_next = entry_reg;
        wrong_next = wrong_reg;
        scan_next  = scan_reg;
        case (func)
            FUNC_TICK:
            begin
                if (entry_reg == ENTRY_IDLE)
                begin
                    sec_next  = (sec_inc >= 8'd60) ? 8'd0 : sec_inc;
                    min_next  = (min_tick >= 8'd60) ? 8'd0 : min_tick;
                    hour_next = (hour_tick >= 8'd24) ? 8'd0 : hour_tick;
                end
            end
            FUNC_KEY:
            begin
                case (entry_reg)
                    ENTRY_IDLE:
                    begin
                        if (key_code == KEY_ONE)
                        begin
                            wrong_next = 1'b0;
                            entry_next = ENTRY_HOUR_TENS;
                        end
                        else
                        begin
                            wrong_next = 1'b1;
                        end
                    end
                    ENTRY_HOUR_TENS:
                    begin
                        hour_next  = key_tens;
                        entry_next = ENTRY_HOUR_UNIT;
                    end
                    ENTRY_HOUR_UNIT:
                    begin
                        hour_next  = hour_reg + key_digit;
                        entry_next = ENTRY_MIN_TENS;
                    end
                    ENTRY_MIN_TENS:
                    begin
                        min_next   = key_tens;
                        entry_next = ENTRY_MIN_UNIT;
                    end
                    ENTRY_MIN_UNIT:
                    begin
                        min_next   = min_reg + key_digit;
                        entry_next = ENTRY_SEC_TENS;
                    end
                    ENTRY_SEC_TENS:
                    begin
                        sec_next   = key_tens;
                        entry_next = ENTRY_SEC_UNIT;
                    end
                    ENTRY_SEC_UNIT:
                    begin
                        sec_next   = sec_reg + key_digit;
                        entry_next = ENTRY_IDLE;
                    end
                    default:
                    begin
                        entry_next = ENTRY_IDLE;
                    end
                endcase
            end
            FUNC_SCAN:
            begin
                scan_next = scan_adv;
            end
            default:
            begin
                scan_next = scan_reg;
            end
        endcase
    end

    // state registers, updated once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg   <= 8'd0;
            min_reg   <= 8'd0;
            hour_reg  <= 8'd0;
            entry_reg <= ENTRY_IDLE;
            wrong_reg <= 1'b0;
            scan_reg  <= 3'd0;
        end
        else if (proc)
        begin
            sec_reg   <= sec_next;
            min_reg   <= min_next;
            hour_reg  <= hour_next;
            entry_reg <= entry_next;
            wrong_reg <= wrong_next;
            scan_reg  <= scan_next;
        end
    end

    // result of the item: state after it, plus the scanned digit
    always_comb
    begin
        result.hours        = hour_next;
        result.minutes      = min_next;
        result.seconds      = sec_next;
        result.entry_step   = entry_next;
        result.wrong_choice = wrong_next;
        result.digit_value  = (func == FUNC_SCAN) ? scan_value : 5'd0;
        result.digit_select = (func == FUNC_SCAN) ? scan_select : SEL_NONE;
    end

    // entry starts only on an idle '1' key
    `TOD_ASSERT_NOW(a_entry_start, proc && entry_reg == ENTRY_IDLE && entry_next != ENTRY_IDLE,
        func == FUNC_KEY && key_code == KEY_ONE)
    // a tick during entry leaves the counters alone
    `TOD_ASSERT_NEXT(a_tick_frozen, proc && func == FUNC_TICK && entry_reg != ENTRY_IDLE,
        $stable(sec_reg) && $stable(min_reg) && $stable(hour_reg))

endmodule

FILE: sv/time_of_day_clock_with_keypad_set.sv
// Time-of-day clock with keypad entry and multiplexed display scan.
// Input channel: in_valid / in_stall with func and key_code. func selects a
// one-second tick, a key press or a display scan step; an unused code only
// reports the counters. Output channel: out_valid / out_stall with the hours,
// minutes and seconds after the item, the entry step, the wrong-choice flag,
// and for a scan step the digit shown and its active-low select line
// (all selects high for other items).
// Path: an item is held in the input register and then in the result register,
// which drives the result ports; a receiver stall can hold it in either one.
// Throughput: one item per cycle while the receiver does not stall; the state
// update is a single pass of counter, compare and divide-by-ten logic between
// the input register and the result register.
// When the receiver stalls, the result register holds; the input register
// still takes one more item, and in_stall rises only once both are full.
// Reset clears the counters to 00:00:00, the entry sequencer to idle, the
// wrong-choice flag and the scan position, and empties both registers.
`include "time_of_day_clock_with_keypad_set_defines.svh"

module time_of_day_clock_with_keypad_set
    import tod_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  logic [7:0] key_code,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] hours,
    output logic [7:0] minutes,
    output logic [7:0] seconds,
    output logic [2:0] entry_step,
    output logic       wrong_choice,
    output logic [4:0] digit_value,
    output logic [5:0] digit_select
);

    logic        in_valid_reg;
    logic [1:0]  func_reg;
    logic [7:0]  key_reg;
    logic        out_valid_reg;
    tod_result_t result_reg;
    tod_result_t result;
    logic        out_open;
    logic        proc;

    // result register can take a new value when empty or being drained
    assign out_open = !out_valid_reg || !out_stall;
    assign proc     = in_valid_reg && out_open;
    assign in_stall = in_valid_reg && !out_open;

    tod_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .proc    (proc),
        .func    (func_reg),
        .key_code(key_reg),
        .result  (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            func_reg <= func;
            key_reg  <= key_code;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_open)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hours        = result_reg.hours;
    assign minutes      = result_reg.minutes;
    assign seconds      = result_reg.seconds;
    assign entry_step   = result_reg.entry_step;
    assign wrong_choice = result_reg.wrong_choice;
    assign digit_value  = result_reg.digit_value;
    assign digit_select = result_reg.digit_select;

    // a scan result drives exactly one select line low
    `TOD_ASSERT_NOW(a_sel_single, out_valid_reg && result_reg.digit_select != SEL_NONE,
        $onehot(~result_reg.digit_select))
    // a non-scan result shows a blank digit
    `TOD_ASSERT_NOW(a_blank_zero, out_valid_reg && result_reg.digit_select == SEL_NONE,
        result_reg.digit_value == 5'd0)
    // a stalled input item stays in the input register
    `TOD_ASSERT_NEXT(a_in_hold, in_valid_reg && in_stall, in_valid_reg)

endmodule

FILE: tb/sv/tb_time_of_day_clock_with_keypad_set.sv
// self-checking testbench for the time-of-day clock with keypad entry and display scan
`timescale 1ns / 1ps

module tb_time_of_day_clock_with_keypad_set
    import tod_pkg::*;
();

    localparam int CLK_PERIOD       = 10;
    localparam int TOTAL_ITEMS      = 1350;
    localparam int QUIET_ITEMS      = 150;
    localparam int LONG_HOLD_AT     = 400;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int N_DIR            = 26;

    // function code with no meaning to the block
    localparam logic [1:0] FUNC_NONE = 2'd3;

    // key codes
    localparam logic [7:0] KEY_ZERO = "0";
    localparam logic [7:0] KEY_ONE  = "1";

    // active-low select per display position
    localparam logic [5:0] SEL_SEC_UNITS  = 6'h1F;
    localparam logic [5:0] SEL_SEC_TENS   = 6'h3E;
    localparam logic [5:0] SEL_MIN_UNITS  = 6'h3D;
    localparam logic [5:0] SEL_MIN_TENS   = 6'h3B;
    localparam logic [5:0] SEL_HOUR_UNITS = 6'h37;
    localparam logic [5:0] SEL_HOUR_TENS  = 6'h2F;

    // display positions in scan order
    localparam logic [2:0] SCAN_SEC_UNITS  = 3'd0;
    localparam logic [2:0] SCAN_SEC_TENS   = 3'd1;
    localparam logic [2:0] SCAN_MIN_UNITS  = 3'd2;
    localparam logic [2:0] SCAN_MIN_TENS   = 3'd3;
    localparam logic [2:0] SCAN_HOUR_UNITS = 3'd4;

    // keys that set 23:59:5x, the last one is random
    localparam logic [7:0] NEAR_MIDNIGHT [5] = '{"2", "3", "5", "9", "5"};

    typedef enum logic [2:0] {
        ENTRY_IDLE,
        ENTRY_HOUR_TENS,
        ENTRY_HOUR_UNITS,
        ENTRY_MIN_TENS,
        ENTRY_MIN_UNITS,
        ENTRY_SEC_TENS,
        ENTRY_SEC_UNITS
    } entry_pos_e;

    typedef struct {
        logic [1:0]  fn;
        logic [7:0]  code;
        bit          typed;
        tod_result_t res;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] func;
    logic [7:0] key_code;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
    logic [2:0] entry_step;
    logic       wrong_choice;
    logic [4:0] digit_value;
    logic [5:0] digit_select;

    // clock state as the block should hold it
    logic [7:0] clk_sec;
    logic [7:0] clk_min;
    logic [7:0] clk_hour;
    entry_pos_e set_pos;
    logic       bad_key;
    logic [2:0] scan_pos;

    tod_result_t expected_q [$];
    tod_result_t want;

    int  n_in;
    int  items_done;
    int  n_out;
    int  err_count;
    int  n_entries;
    int  n_rollovers;
    int  n_scans;
    int  stuck_cycles;
    bit  quiet;
    bit  long_hold_done;

    // directed rows, fixed results only where they are obvious
    stim_row_t dir_rows [N_DIR] = '{
        '{FUNC_SCAN, 8'h00, 1'b1,
          {8'd0, 8'd0, 8'd0, ENTRY_IDLE, 1'b0, 5'd0, SEL_SEC_UNITS}},
        '{FUNC_NONE, 8'hFF, 1'b1,
          {8'd0, 8'd0, 8'd0, ENTRY_IDLE, 1'b0, 5'd0, SEL_NONE}},
        '{FUNC_TICK, 8'h00, 1'b1,
          {8'd0, 8'd0, 8'd1, ENTRY_IDLE, 1'b0, 5'd0, SEL_NONE}},
        '{FUNC_KEY, 8'h00, 1'b1,
          {8'd0, 8'd0, 8'd1, ENTRY_IDLE, 1'b1, 5'd0, SEL_NONE}},
        '{FUNC_KEY, KEY_ONE, 1'b1,
          {8'd0, 8'd0, 8'd1, ENTRY_HOUR_TENS, 1'b0, 5'd0, SEL_NONE}},
        // tick while entering is dropped
        '{FUNC_TICK, 8'hFF, 1'b1,
          {8'd0, 8'd0, 8'd1, ENTRY_HOUR_TENS, 1'b0, 5'd0, SEL_NONE}},
        '{FUNC_KEY, "2", 1'b0, '0},
        '{FUNC_SCAN, 8'h00, 1'b0, '0},
        '{FUNC_KEY, "3", 1'b0, '0},
        '{FUNC_KEY, "5", 1'b0, '0},
        '{FUNC_KEY, "9", 1'b0, '0},
        '{FUNC_KEY, "5", 1'b0, '0},
        '{FUNC_KEY, "9", 1'b0, '0},
        // 23:59:59 rolls over to midnight
        '{FUNC_TICK, 8'h00, 1'b1,
          {8'd0, 8'd0, 8'd0, ENTRY_IDLE, 1'b0, 5'd0, SEL_NONE}},
        '{FUNC_KEY, KEY_ONE, 1'b1,
          {8'd0, 8'd0, 8'd0, ENTRY_HOUR_TENS, 1'b0, 5'd0, SEL_NONE}},
        // extreme codes wrap: hours 230, minutes and seconds 255
        '{FUNC_KEY, 8'hFF, 1'b0, '0},
        '{FUNC_KEY, 8'h00, 1'b0, '0},
        '{FUNC_KEY, "I", 1'b0, '0},
        '{FUNC_KEY, "5", 1'b0, '0},
        '{FUNC_KEY, "I", 1'b0, '0},
        '{FUNC_KEY, "5", 1'b0, '0},
        // remaining positions, tens digits above 9
        '{FUNC_SCAN, 8'hAA, 1'b0, '0},
        '{FUNC_SCAN, 8'h55, 1'b0, '0},
        '{FUNC_SCAN, 8'h00, 1'b0, '0},
        '{FUNC_SCAN, 8'hFF, 1'b0, '0},
        // seconds wrap past 255, minutes and hours fold back
        '{FUNC_TICK, 8'h00, 1'b0, '0}
    };

    time_of_day_clock_with_keypad_set u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .key_code     (key_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hours        (hours),
        .minutes      (minutes),
        .seconds      (seconds),
        .entry_step   (entry_step),
        .wrong_choice (wrong_choice),
        .digit_value  (digit_value),
        .digit_select (digit_select)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // next clock state and result for one item
    function automatic tod_result_t advance_clock(logic [1:0] fn, logic [7:0] code);
        tod_result_t r;
        logic [7:0]  dig;
        logic [7:0]  tens;
        logic [2:0]  p;
        r.digit_value  = 5'd0;
        r.digit_select = SEL_NONE;
        case (fn)
            FUNC_TICK:
            begin
                if (set_pos == ENTRY_IDLE)
                begin
                    clk_sec = clk_sec + 8'd1;
                    if (clk_sec >= 8'd60)
                    begin
                        clk_sec = 8'd0;
                        clk_min = clk_min + 8'd1;
                    end
                    if (clk_min >= 8'd60)
                    begin
                        clk_min  = 8'd0;
                        clk_hour = clk_hour + 8'd1;
                    end
                    if (clk_hour >= 8'd24)
                    begin
                        clk_hour = 8'd0;
                        n_rollovers++;
                    end
                end
            end
            FUNC_KEY:
            begin
                dig  = code - KEY_ZERO;
                tens = dig * 8'd10;
                if (set_pos == ENTRY_IDLE)
                begin
                    if (code == KEY_ONE)
                    begin
                        bad_key = 1'b0;
                        set_pos = ENTRY_HOUR_TENS;
                        n_entries++;
                    end
                    else
                        bad_key = 1'b1;
                end
                else
                begin
                    case (set_pos)
                        ENTRY_HOUR_TENS:  clk_hour = tens;
                        ENTRY_HOUR_UNITS: clk_hour = clk_hour + dig;
                        ENTRY_MIN_TENS:   clk_min = tens;
                        ENTRY_MIN_UNITS:  clk_min = clk_min + dig;
                        ENTRY_SEC_TENS:   clk_sec = tens;
                        default:          clk_sec = clk_sec + dig;
                    endcase
                    set_pos = (set_pos == ENTRY_SEC_UNITS) ? ENTRY_IDLE
                                                           : entry_pos_e'(set_pos + 3'd1);
                end
            end
            FUNC_SCAN:
            begin
                p = (32'(scan_pos) >= DISPLAY_DIGITS) ? SCAN_SEC_UNITS : scan_pos;
                case (p)
                    SCAN_SEC_UNITS:
                    begin
                        r.digit_value  = 5'(clk_sec % 8'd10);
                        r.digit_select = SEL_SEC_UNITS;
                    end
                    SCAN_SEC_TENS:
                    begin
                        r.digit_value  = 5'(clk_sec / 8'd10);
                        r.digit_select = SEL_SEC_TENS;
                    end
                    SCAN_MIN_UNITS:
                    begin
                        r.digit_value  = 5'(clk_min % 8'd10);
                        r.digit_select = SEL_MIN_UNITS;
                    end
                    SCAN_MIN_TENS:
                    begin
                        r.digit_value  = 5'(clk_min / 8'd10);
                        r.digit_select = SEL_MIN_TENS;
                    end
                    SCAN_HOUR_UNITS:
                    begin
                        r.digit_value  = 5'(clk_hour % 8'd10);
                        r.digit_select = SEL_HOUR_UNITS;
                    end
                    default:
                    begin
                        r.digit_value  = 5'(clk_hour / 8'd10);
                        r.digit_select = SEL_HOUR_TENS;
                    end
                endcase
                scan_pos = (32'(p) + 1 >= DISPLAY_DIGITS) ? SCAN_SEC_UNITS : 3'(p + 3'd1);
                n_scans++;
            end
            default:
            begin
            end
        endcase
        r.hours        = clk_hour;
        r.minutes      = clk_min;
        r.seconds      = clk_sec;
        r.entry_step   = set_pos;
        r.wrong_choice = bad_key;
        return r;
    endfunction

    // offer one item, wait for its transfer, then log what it should produce
    task automatic send_item(input logic [1:0] fn, input logic [7:0] code,
                             input bit typed = 1'b0, input tod_result_t typed_res = '0);
        tod_result_t pred;
        bit          ignored;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= fn;
        key_code <= code;
        do
            @(posedge clk);
        while (in_stall);
        ignored = (fn == FUNC_NONE) || (fn == FUNC_TICK && set_pos != ENTRY_IDLE);
        pred = advance_clock(fn, code);
        expected_q.push_back(typed ? typed_res : pred);
        n_in++;
        if (!ignored)
            items_done++;
        quiet = (items_done >= TOTAL_ITEMS - QUIET_ITEMS);
    endtask

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            err_count++;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_out++;
            if (expected_q.size() == 0)
            begin
                $error("result transfer with no expectation waiting");
                err_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("hours", want.hours, hours);
                check_field("minutes", want.minutes, minutes);
                check_field("seconds", want.seconds, seconds);
                check_field("entry_step", 8'(want.entry_step), 8'(entry_step));
                check_field("wrong_choice", 8'(want.wrong_choice), 8'(wrong_choice));
                check_field("digit_value", 8'(want.digit_value), 8'(digit_value));
                check_field("digit_select", 8'(want.digit_select), 8'(digit_select));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stall bursts plus one long hold to back up the block
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && n_in >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // reset, directed rows, random traffic, drain
    initial
    begin
        int         k;
        bit         near;
        logic [7:0] code;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        func       = FUNC_TICK;
        key_code   = 8'h00;
        clk_sec    = 8'd0;
        clk_min    = 8'd0;
        clk_hour   = 8'd0;
        set_pos    = ENTRY_IDLE;
        bad_key    = 1'b0;
        scan_pos   = SCAN_SEC_UNITS;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
            send_item(dir_rows[i].fn, dir_rows[i].code, dir_rows[i].typed, dir_rows[i].res);

        while (items_done < TOTAL_ITEMS)
        begin
            case ($urandom_range(0, 9))
                // full six-key entry, sometimes close to midnight
                0, 1, 2, 3:
                begin
                    send_item(FUNC_KEY, KEY_ONE);
                    near = ($urandom_range(0, 3) == 0);
                    for (k = 0; k < 6; k++)
                    begin
                        if ($urandom_range(0, 7) == 0)
                            send_item($urandom_range(0, 1) ? FUNC_TICK : FUNC_SCAN,
                                      8'($urandom));
                        if ($urandom_range(0, 9) == 0)
                            code = 8'($urandom);
                        else if (near && k < 5)
                            code = NEAR_MIDNIGHT[k];
                        else
                            code = KEY_ZERO + 8'($urandom_range(0,
                                       k == 0 ? 2 : (k % 2 == 0 ? 5 : 9)));
                        send_item(FUNC_KEY, code);
                    end
                end
                // run of ticks
                4, 5, 6:
                    repeat ($urandom_range(1, 70)) send_item(FUNC_TICK, 8'($urandom));
                // run of scan steps
                7, 8:
                    repeat ($urandom_range(1, 12)) send_item(FUNC_SCAN, 8'($urandom));
                // noise: any function, any code
                default:
                    repeat ($urandom_range(1, 4)) send_item(2'($urandom), 8'($urandom));
            endcase
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items sent (%0d acting on the clock), %0d results checked",
                 n_in, items_done, n_out);
        $display("%0d keypad entries, %0d midnight rollovers, %0d scan steps, %0d mismatches",
                 n_entries, n_rollovers, n_scans, err_count);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
